>>> src/three_way_quicksort_engine_unit_macros.svh
`ifndef THREE_WAY_QUICKSORT_ENGINE_UNIT_MACROS_SVH
`define THREE_WAY_QUICKSORT_ENGINE_UNIT_MACROS_SVH

// clocked check, off while reset is held
`define TQS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also runs during reset
`define TQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/tqs_pkg.sv
`default_nettype none
package tqs_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int STK_W       = 2 * IDX_W;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [STK_W-1:0]       stk_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] sample_value;
    logic                      batch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] sorted_value;
    logic                      run_end;
    logic                      dropped_flag;
  } out_item_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    idx_t   raddr;
  } store_req_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    stk_t wdata;
    idx_t raddr;
  } stack_req_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEED,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_PAIR,
    ST_PAIR_WR,
    ST_SCAN,
    ST_CMP,
    ST_LT_WR,
    ST_GT_RD,
    ST_GT_WR,
    ST_PUSH_LO,
    ST_PUSH_HI,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> src/tqs_ram.sv
`default_nettype none
module tqs_ram #(
  parameter int WIDTH   = 32,
  parameter int DEPTH_P = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/tqs_ctrl.sv
`default_nettype none
module tqs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tqs_pkg::in_item_t   in_item,
  output logic                     out_strobe,
  output tqs_pkg::out_item_t       out_item,
  output tqs_pkg::store_req_t      store_req,
  input  wire tqs_pkg::value_t     store_rdata,
  output tqs_pkg::stack_req_t      stack_req,
  input  wire tqs_pkg::stk_t       stack_rdata
);

  tqs_pkg::state_t state_r, state_nxt;
  tqs_pkg::cnt_t   fill_r, fill_nxt;
  logic            ovf_r, ovf_nxt;
  tqs_pkg::cnt_t   sp_r, sp_nxt;
  tqs_pkg::idx_t   lo_r, lo_nxt;
  tqs_pkg::idx_t   hi_r, hi_nxt;
  tqs_pkg::idx_t   lt_r, lt_nxt;
  tqs_pkg::cnt_t   mid_r, mid_nxt;
  tqs_pkg::idx_t   gt_r, gt_nxt;
  tqs_pkg::value_t pivot_r, pivot_nxt;
  tqs_pkg::value_t tmp_r, tmp_nxt;
  tqs_pkg::cnt_t   k_r, k_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_drop_r, out_drop_nxt;

  tqs_pkg::idx_t   pop_lo, pop_hi;
  logic            v_lt_pivot, v_eq_pivot, pivot_lt_v;

  assign pop_lo = stack_rdata[tqs_pkg::STK_W-1:tqs_pkg::IDX_W];
  assign pop_hi = stack_rdata[tqs_pkg::IDX_W-1:0];

  // shared signed comparator: pivot against the word just read
  assign v_lt_pivot = $signed(store_rdata) < $signed(pivot_r);
  assign pivot_lt_v = $signed(pivot_r) < $signed(store_rdata);
  assign v_eq_pivot = store_rdata == pivot_r;

  assign busy       = state_r != tqs_pkg::ST_LOAD;
  assign out_strobe = out_vld_r;
  assign out_item.sorted_value = tqs_pkg::field_t'(store_rdata);
  assign out_item.run_end      = out_last_r;
  assign out_item.dropped_flag = out_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tqs_pkg::ST_LOAD;
      fill_r    <= '0;
      ovf_r     <= 1'b0;
      sp_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      ovf_r     <= ovf_nxt;
      sp_r      <= sp_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    lt_r       <= lt_nxt;
    mid_r      <= mid_nxt;
    gt_r       <= gt_nxt;
    pivot_r    <= pivot_nxt;
    tmp_r      <= tmp_nxt;
    k_r        <= k_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    sp_nxt       = sp_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    lt_nxt       = lt_r;
    mid_nxt      = mid_r;
    gt_nxt       = gt_r;
    pivot_nxt    = pivot_r;
    tmp_nxt      = tmp_r;
    k_nxt        = k_r;
    out_vld_nxt  = 1'b0;
    out_last_nxt = out_last_r;
    out_drop_nxt = out_drop_r;
    store_req    = '0;
    stack_req    = '0;

    unique case (state_r)
      tqs_pkg::ST_LOAD: begin
        if (start) begin
          if (fill_r < tqs_pkg::cnt_t'(tqs_pkg::DEPTH)) begin
            store_req.we    = 1'b1;
            store_req.waddr = fill_r[tqs_pkg::IDX_W-1:0];
            store_req.wdata = tqs_pkg::value_t'($unsigned(in_item.sample_value));
            fill_nxt        = fill_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item.batch_end) begin
            state_nxt = tqs_pkg::ST_SEED;
          end
        end
      end

      tqs_pkg::ST_SEED: begin
        if (fill_r > tqs_pkg::cnt_t'(1)) begin
          stack_req.we    = 1'b1;
          stack_req.waddr = '0;
          stack_req.wdata = {tqs_pkg::idx_t'(0), tqs_pkg::idx_t'(fill_r - 1'b1)};
          sp_nxt          = tqs_pkg::cnt_t'(1);
        end
        state_nxt = tqs_pkg::ST_POP;
      end

      tqs_pkg::ST_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = tqs_pkg::ST_EMIT;
        end else begin
          stack_req.raddr = tqs_pkg::idx_t'(sp_r - 1'b1);
          sp_nxt          = sp_r - 1'b1;
          state_nxt       = tqs_pkg::ST_RANGE;
        end
      end

      tqs_pkg::ST_RANGE: begin
        lo_nxt          = pop_lo;
        hi_nxt          = pop_hi;
        store_req.raddr = pop_hi;
        state_nxt       = tqs_pkg::ST_PIVOT;
      end

      tqs_pkg::ST_PIVOT: begin
        pivot_nxt = store_rdata;
        if (hi_r == lo_r + 1'b1) begin
          store_req.raddr = lo_r;
          state_nxt       = tqs_pkg::ST_PAIR;
        end else begin
          lt_nxt    = lo_r;
          mid_nxt   = {1'b0, lo_r};
          gt_nxt    = hi_r;
          state_nxt = tqs_pkg::ST_SCAN;
        end
      end

      tqs_pkg::ST_PAIR: begin
        // pivot_r holds the high word, store_rdata the low word
        if (pivot_lt_v) begin
          store_req.we    = 1'b1;
          store_req.waddr = lo_r;
          store_req.wdata = pivot_r;
          tmp_nxt         = store_rdata;
          state_nxt       = tqs_pkg::ST_PAIR_WR;
        end else begin
          state_nxt = tqs_pkg::ST_POP;
        end
      end

      tqs_pkg::ST_PAIR_WR: begin
        store_req.we    = 1'b1;
        store_req.waddr = hi_r;
        store_req.wdata = tmp_r;
        state_nxt       = tqs_pkg::ST_POP;
      end

      tqs_pkg::ST_SCAN: begin
        if (mid_r <= {1'b0, gt_r}) begin
          store_req.raddr = mid_r[tqs_pkg::IDX_W-1:0];
          state_nxt       = tqs_pkg::ST_CMP;
        end else begin
          state_nxt = tqs_pkg::ST_PUSH_LO;
        end
      end

      tqs_pkg::ST_CMP: begin
        priority if (v_lt_pivot) begin
          // entries in [lt, mid) all equal the pivot
          store_req.we    = 1'b1;
          store_req.waddr = lt_r;
          store_req.wdata = store_rdata;
          if ({1'b0, lt_r} == mid_r) begin
            lt_nxt    = lt_r + 1'b1;
            mid_nxt   = mid_r + 1'b1;
            state_nxt = tqs_pkg::ST_SCAN;
          end else begin
            state_nxt = tqs_pkg::ST_LT_WR;
          end
        end else if (v_eq_pivot) begin
          mid_nxt   = mid_r + 1'b1;
          state_nxt = tqs_pkg::ST_SCAN;
        end else begin
          tmp_nxt         = store_rdata;
          store_req.raddr = gt_r;
          state_nxt       = tqs_pkg::ST_GT_RD;
        end
      end

      tqs_pkg::ST_LT_WR: begin
        store_req.we    = 1'b1;
        store_req.waddr = mid_r[tqs_pkg::IDX_W-1:0];
        store_req.wdata = pivot_r;
        lt_nxt          = lt_r + 1'b1;
        mid_nxt         = mid_r + 1'b1;
        state_nxt       = tqs_pkg::ST_SCAN;
      end

      tqs_pkg::ST_GT_RD: begin
        store_req.we    = 1'b1;
        store_req.waddr = mid_r[tqs_pkg::IDX_W-1:0];
        store_req.wdata = store_rdata;
        state_nxt       = tqs_pkg::ST_GT_WR;
      end

      tqs_pkg::ST_GT_WR: begin
        store_req.we    = 1'b1;
        store_req.waddr = gt_r;
        store_req.wdata = tmp_r;
        gt_nxt          = gt_r - 1'b1;
        state_nxt       = tqs_pkg::ST_SCAN;
      end

      tqs_pkg::ST_PUSH_LO: begin
        if ({1'b0, lt_r} > {1'b0, lo_r} + 1'b1) begin
          stack_req.we    = 1'b1;
          stack_req.waddr = sp_r[tqs_pkg::IDX_W-1:0];
          stack_req.wdata = {lo_r, tqs_pkg::idx_t'(lt_r - 1'b1)};
          sp_nxt          = sp_r + 1'b1;
        end
        state_nxt = tqs_pkg::ST_PUSH_HI;
      end

      tqs_pkg::ST_PUSH_HI: begin
        if (mid_r < {1'b0, hi_r}) begin
          stack_req.we    = 1'b1;
          stack_req.waddr = sp_r[tqs_pkg::IDX_W-1:0];
          stack_req.wdata = {mid_r[tqs_pkg::IDX_W-1:0], hi_r};
          sp_nxt          = sp_r + 1'b1;
        end
        state_nxt = tqs_pkg::ST_POP;
      end

      tqs_pkg::ST_EMIT: begin
        store_req.raddr = k_r[tqs_pkg::IDX_W-1:0];
        out_vld_nxt     = 1'b1;
        out_last_nxt    = k_r == fill_r - 1'b1;
        out_drop_nxt    = ovf_r;
        k_nxt           = k_r + 1'b1;
        if (k_r == fill_r - 1'b1) begin
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = tqs_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = tqs_pkg::ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/three_way_quicksort_engine_unit.sv
`default_nettype none
// Batch sorter. Items are taken while busy is low, one per cycle: each one
// stores its value, up to 64 per batch; further values are dropped and every
// result of that batch then carries dropped_flag. The item with batch_end set
// makes busy rise and starts an in-place quicksort with three-way partitioning
// (pivot is the last entry of each range; two-entry ranges take one compare
// and swap), all on a single-port-per-cycle value memory and a range stack
// memory; each partition pass makes one memory read or write each cycle. The n
// results then come out on consecutive cycles, ascending, one per out_strobe,
// the last with run_end; the receiver cannot stall them and must take each on
// its cycle. busy falls in the cycle that shows the last result.
module three_way_quicksort_engine_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire tqs_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output tqs_pkg::out_item_t      out_item
);

  tqs_pkg::store_req_t store_req;
  tqs_pkg::stack_req_t stack_req;
  tqs_pkg::value_t     store_rdata;
  tqs_pkg::stk_t       stack_rdata;

  tqs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_item    (out_item),
    .store_req   (store_req),
    .store_rdata (store_rdata),
    .stack_req   (stack_req),
    .stack_rdata (stack_rdata)
  );

  tqs_ram #(
    .WIDTH   (tqs_pkg::VALUE_WIDTH),
    .DEPTH_P (tqs_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_req.we),
    .waddr (store_req.waddr),
    .wdata (store_req.wdata),
    .raddr (store_req.raddr),
    .rdata (store_rdata)
  );

  tqs_ram #(
    .WIDTH   (tqs_pkg::STK_W),
    .DEPTH_P (tqs_pkg::DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stack_req.we),
    .waddr (stack_req.waddr),
    .wdata (stack_req.wdata),
    .raddr (stack_req.raddr),
    .rdata (stack_rdata)
  );

endmodule
`default_nettype wire

>>> src/tqs_checker.sv
`default_nettype none
`include "three_way_quicksort_engine_unit_macros.svh"
module tqs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire tqs_pkg::in_item_t  in_item,
  input wire logic               out_strobe,
  input wire tqs_pkg::out_item_t out_item
);

  `TQS_ASSERT(a_end_starts_sort, clk, rst_n, (start && !busy && in_item.batch_end) |=> busy, "batch end item did not start the sort")
  `TQS_ASSERT(a_load_stays_ready, clk, rst_n, (start && !busy && !in_item.batch_end) |=> !busy, "block went busy on a plain load item")
  `TQS_ASSERT(a_result_in_run, clk, rst_n, out_strobe |-> $past(busy), "result outside a sort run")
  `TQS_ASSERT(a_run_gapless, clk, rst_n, (out_strobe && !out_item.run_end) |=> out_strobe, "gap inside a result run")
  `TQS_ASSERT(a_run_closes, clk, rst_n, (out_strobe && out_item.run_end) |=> !out_strobe, "result after the run end")

endmodule

bind three_way_quicksort_engine_unit tqs_checker u_tqs_checker (.*);
`default_nettype wire

>>> tb/three_way_quicksort_engine_unit_checker.sv
`timescale 1ns / 1ps
module three_way_quicksort_engine_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  tqs_pkg::in_item_t  in_item,
  input  logic               out_strobe,
  input  tqs_pkg::out_item_t out_item,
  output int                 error_count,
  output int                 outstanding
);

  logic signed [tqs_pkg::VALUE_WIDTH-1:0] batch_vals [tqs_pkg::DEPTH];
  int                  fill_count    = 0;
  logic                overflow_seen = 1'b0;
  tqs_pkg::out_item_t  sorted_q [$];
  int                  errs          = 0;

  // Order the held batch ascending and queue one result per value.
  task automatic queue_sorted_batch();
    logic signed [tqs_pkg::VALUE_WIDTH-1:0] key;
    tqs_pkg::out_item_t                      want;
    int                                      j;
    for (int i = 1; i < fill_count; i++) begin
      key = batch_vals[i];
      j = i - 1;
      while (j >= 0 && batch_vals[j] > key) begin
        batch_vals[j + 1] = batch_vals[j];
        j--;
      end
      batch_vals[j + 1] = key;
    end
    for (int k = 0; k < fill_count; k++) begin
      want.sorted_value = tqs_pkg::field_t'(tqs_pkg::value_t'(batch_vals[k]));
      want.run_end      = (k == fill_count - 1);
      want.dropped_flag = overflow_seen;
      sorted_q.push_back(want);
    end
  endtask

  task automatic take_item(input tqs_pkg::in_item_t it);
    if (fill_count < tqs_pkg::DEPTH) begin
      batch_vals[fill_count] = it.sample_value[tqs_pkg::VALUE_WIDTH-1:0];
      fill_count++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (it.batch_end) begin
      queue_sorted_batch();
      fill_count    = 0;
      overflow_seen = 1'b0;
    end
  endtask

  task automatic check_result(input tqs_pkg::out_item_t got);
    tqs_pkg::out_item_t want;
    if (sorted_q.size() == 0) begin
      errs++;
      $display("%0t: unexpected result: value %0d run_end %b dropped_flag %b",
               $time, got.sorted_value, got.run_end, got.dropped_flag);
    end else begin
      want = sorted_q.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        errs++;
        $display("%0t: sorted_value expected %0d got %0d",
                 $time, want.sorted_value, got.sorted_value);
      end
      if (got.run_end !== want.run_end) begin
        errs++;
        $display("%0t: run_end expected %b got %b", $time, want.run_end, got.run_end);
      end
      if (got.dropped_flag !== want.dropped_flag) begin
        errs++;
        $display("%0t: dropped_flag expected %b got %b",
                 $time, want.dropped_flag, got.dropped_flag);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_count    = 0;
      overflow_seen = 1'b0;
      sorted_q.delete();
    end else begin
      if (out_strobe) begin
        check_result(out_item);
      end
      if (start && !busy) begin
        take_item(in_item);
      end
    end
    error_count <= errs;
    outstanding <= sorted_q.size();
  end

endmodule

>>> tb/three_way_quicksort_engine_unit_tb.sv
`timescale 1ns / 1ps
module three_way_quicksort_engine_unit_tb;

  localparam int     ITEMS_PER_PHASE = 100;
  localparam int     TAIL_CYCLES     = 200;
  localparam longint TIMEOUT_NS      = 64'd12_000_000;

  typedef enum int {
    PAT_RANDOM,
    PAT_DUPS,
    PAT_ASCEND,
    PAT_DESCEND,
    PAT_EXTREME
  } pattern_t;

  logic               clk;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  tqs_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               out_strobe;
  tqs_pkg::out_item_t out_item;
  int                 error_count;
  int                 outstanding;

  int items_sent = 0;
  int idle_pct   = 0;

  three_way_quicksort_engine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  three_way_quicksort_engine_unit_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_item    (out_item),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_item(input logic signed [tqs_pkg::FIELD_W-1:0] value, input logic last);
    tqs_pkg::in_item_t junk;
    tqs_pkg::in_item_t it;
    while ($urandom_range(99) < idle_pct) begin
      junk.sample_value = $urandom;
      junk.batch_end    = 1'($urandom_range(1));
      start   <= 1'b0;
      in_item <= junk;
      @(posedge clk);
    end
    it.sample_value = value;
    it.batch_end    = last;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_batch(input int len);
    pattern_t                          pat;
    logic signed [tqs_pkg::FIELD_W-1:0] base;
    logic signed [tqs_pkg::FIELD_W-1:0] v;
    pat  = pattern_t'($urandom_range(int'(PAT_EXTREME)));
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      case (pat)
        PAT_DUPS:    v = $signed($urandom_range(6)) - 3;
        PAT_ASCEND:  v = base + i;
        PAT_DESCEND: v = base - i;
        PAT_EXTREME: begin
          v = $urandom_range(1) ? '1 : '0;
          if ($urandom_range(1)) v[tqs_pkg::FIELD_W-1] = ~v[tqs_pkg::FIELD_W-1];
        end
        default:     v = $urandom;
      endcase
      send_item(v, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int len;
    int batch_no;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-entry batches at both extremes
    idle_pct = 21;
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7fff_ffff, 1'b1);
    // pairs: one swapped, one already ordered
    send_item(5, 1'b0);
    send_item(-5, 1'b1);
    send_item(-1, 1'b0);
    send_item(0, 1'b1);
    // extremes mixed
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh8000_0001, 1'b0);
    send_item(32'sh7fff_fffe, 1'b1);
    // duplicates around the pivot
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    send_item(-2, 1'b0);
    send_item(3, 1'b0);
    send_item(-2, 1'b0);
    send_item(3, 1'b1);
    // all equal
    send_item(9, 1'b0);
    send_item(9, 1'b0);
    send_item(9, 1'b1);
    wait_drained();

    items_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 21 : (phase == 1) ? 58 : 0;
      batch_no = 0;
      while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
        if (batch_no == 2) begin
          // full store in phase 0, end item dropped in phase 1, several dropped in phase 2
          len = tqs_pkg::DEPTH + phase + ((phase == 2) ? $urandom_range(2) : 0);
        end else if ($urandom_range(99) < 8) begin
          len = $urandom_range(tqs_pkg::DEPTH - 1, 9);
        end else begin
          len = $urandom_range(8, 1);
        end
        send_random_batch(len);
        batch_no++;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("three_way_quicksort_engine_unit_tb passed");
    end else begin
      $display("three_way_quicksort_engine_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("three_way_quicksort_engine_unit_tb failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/tqs_pkg.sv
src/tqs_ram.sv
src/tqs_ctrl.sv
src/three_way_quicksort_engine_unit.sv
src/tqs_checker.sv
tb/three_way_quicksort_engine_unit_checker.sv
tb/three_way_quicksort_engine_unit_tb.sv
